// ===== sv/lli_pkg.sv =====
// Shared constants for the line-line intersection block.
`timescale 1ns / 1ps
package lli_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int THRESH_W        = 48;
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(1);

endpackage

// ===== sv/lli_in_if.sv =====
// Input channel: one pair of lines, two points each.
`timescale 1ns / 1ps
interface lli_in_if #(
  parameter int CW = 24
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

// ===== sv/lli_out_if.sv =====
// Output channel: intersection point and flags.
`timescale 1ns / 1ps
interface lli_out_if #(
  parameter int CW = 24
);
  logic                 valid;
  logic                 ready;
  logic                 intersects;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  logic                 saturated;

  modport source (
    output valid, intersects, cross_x, cross_y, saturated,
    input  ready
  );
  modport sink (
    input  valid, intersects, cross_x, cross_y, saturated,
    output ready
  );
endinterface

// ===== sv/line_line_intersection.sv =====
// Line-line intersection: usage
//   in_chan carries one request: two lines, each as start and end point,
//   signed fixed point. out_chan returns one result per request, in order:
//   intersects, cross_x, cross_y, saturated. Both use valid/ready; a request
//   or result moves on a clock edge where both are high.
//   cfg_we_i/cfg_wdata_i write the parallel threshold (reset value 1); write
//   only while the pipeline is empty.
//   Pipeline: COORD_WIDTH + 8 register stages (7 setup stages, one divider
//   stage per quotient bit, one output stage).
//   Throughput: one request per cycle while out_chan is not stalled. The
//   divider is fully unrolled, one restoring step per stage, so it never
//   blocks the input.
//   When out_chan.ready is low with a result waiting, the whole pipeline
//   holds and in_chan.ready drops; nothing is lost or repeated.
//   Reset (rst_ni low, asynchronous) empties the pipeline and restores the
//   threshold. There is no state between requests.
`timescale 1ns / 1ps
module line_line_intersection import lli_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lli_in_if.sink              in_chan,
  lli_out_if.source           out_chan,
  input  logic                cfg_we_i,
  input  logic [THRESH_W-1:0] cfg_wdata_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int XW   = PW + 1;
  localparam int MW   = XW;
  localparam int LW   = (MW + 1) / 2;
  localparam int HW   = MW - LW;
  localparam int PRW  = MW + DW;
  localparam int RW   = CW + 2;
  localparam int CMPW = (MW > THRESH_W) ? MW : THRESH_W;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [MW-1:0] dmag;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic          par;
  } sb_t;

  logic en;
  logic [THRESH_W-1:0] thr_q;
  logic [7:1] v_q;
  logic [CW-1:0] dv_q;

  // stage 1
  logic signed [DW-1:0] ax1_q, ay1_q, bx1_q, by1_q, cx1_q, cy1_q;
  logic [CW-1:0] sx1_q, sy1_q;
  // stage 2
  logic signed [PW-1:0] pab2_q, pba2_q, pcb2_q, pcbx2_q;
  logic signed [DW-1:0] ax2_q, ay2_q;
  logic [CW-1:0] sx2_q, sy2_q;
  // stage 3
  logic signed [XW-1:0] den3_q, num3_q;
  logic signed [DW-1:0] ax3_q, ay3_q;
  logic [CW-1:0] sx3_q, sy3_q;
  // stage 4
  logic [MW-1:0] dmag4_d, nmag4_d, dmag4_q, nmag4_q;
  logic [DW-1:0] amx4_q, amy4_q;
  logic negx4_q, negy4_q, par4_q;
  logic [CW-1:0] sx4_q, sy4_q;
  // stage 5
  logic [LW+DW-1:0] pxl5_q, pyl5_q;
  logic [HW+DW-1:0] pxh5_q, pyh5_q;
  logic [MW-1:0] dmag5_q;
  logic negx5_q, negy5_q, par5_q;
  logic [CW-1:0] sx5_q, sy5_q;
  // stage 6
  logic [PRW-1:0] prx6_q, pry6_q;
  logic [MW-1:0] dmag6_q;
  logic negx6_q, negy6_q, par6_q;
  logic [CW-1:0] sx6_q, sy6_q;
  // stage 7 and divider
  logic [PRW-1:0] dlim;
  logic [PRW-1:0] rx_q [0:CW];
  logic [PRW-1:0] ry_q [0:CW];
  logic [CW-1:0]  qx_q [0:CW];
  logic [CW-1:0]  qy_q [0:CW];
  sb_t            sb_q [0:CW];
  logic [PRW-1:0] rx_d [1:CW];
  logic [PRW-1:0] ry_d [1:CW];
  logic [CW-1:0]  qx_d [1:CW];
  logic [CW-1:0]  qy_d [1:CW];
  // output
  logic out_valid_q;
  logic [CW:0] fx, fy;

  assign en            = !out_valid_q || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // v_q[7] tracks stage 7, dv_q[k] tracks divider stage k+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[6:1], in_chan.valid};
      dv_q        <= {dv_q[CW-2:0], v_q[7]};
      out_valid_q <= dv_q[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= DW'(in_chan.first_end_x) - DW'(in_chan.first_start_x);
      ay1_q <= DW'(in_chan.first_end_y) - DW'(in_chan.first_start_y);
      bx1_q <= DW'(in_chan.second_end_x) - DW'(in_chan.second_start_x);
      by1_q <= DW'(in_chan.second_end_y) - DW'(in_chan.second_start_y);
      cx1_q <= DW'(in_chan.second_start_x) - DW'(in_chan.first_start_x);
      cy1_q <= DW'(in_chan.second_start_y) - DW'(in_chan.first_start_y);
      sx1_q <= in_chan.first_start_x;
      sy1_q <= in_chan.first_start_y;

      pab2_q  <= PW'(ax1_q) * PW'(by1_q);
      pba2_q  <= PW'(ay1_q) * PW'(bx1_q);
      pcb2_q  <= PW'(cx1_q) * PW'(by1_q);
      pcbx2_q <= PW'(cy1_q) * PW'(bx1_q);
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;

      den3_q <= XW'(pab2_q) - XW'(pba2_q);
      num3_q <= XW'(pcb2_q) - XW'(pcbx2_q);
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;

      dmag4_q <= dmag4_d;
      nmag4_q <= nmag4_d;
      amx4_q  <= ax3_q[DW-1] ? DW'(-ax3_q) : DW'(ax3_q);
      amy4_q  <= ay3_q[DW-1] ? DW'(-ay3_q) : DW'(ay3_q);
      negx4_q <= num3_q[XW-1] ^ ax3_q[DW-1] ^ den3_q[XW-1];
      negy4_q <= num3_q[XW-1] ^ ay3_q[DW-1] ^ den3_q[XW-1];
      // a zero cross product is parallel even with a zero threshold
      par4_q  <= (dmag4_d == '0) || (CMPW'(dmag4_d) < CMPW'(thr_q));
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;

      // |num| * |dir| in two partial products
      pxl5_q  <= (LW+DW)'(nmag4_q[LW-1:0]) * (LW+DW)'(amx4_q);
      pxh5_q  <= (HW+DW)'(nmag4_q[MW-1:LW]) * (HW+DW)'(amx4_q);
      pyl5_q  <= (LW+DW)'(nmag4_q[LW-1:0]) * (LW+DW)'(amy4_q);
      pyh5_q  <= (HW+DW)'(nmag4_q[MW-1:LW]) * (HW+DW)'(amy4_q);
      dmag5_q <= dmag4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      par5_q  <= par4_q;
      sx5_q   <= sx4_q;
      sy5_q   <= sy4_q;

      prx6_q  <= PRW'(pxl5_q) + (PRW'(pxh5_q) << LW);
      pry6_q  <= PRW'(pyl5_q) + (PRW'(pyh5_q) << LW);
      dmag6_q <= dmag5_q;
      negx6_q <= negx5_q;
      negy6_q <= negy5_q;
      par6_q  <= par5_q;
      sx6_q   <= sx5_q;
      sy6_q   <= sy5_q;

      // quotient needs CW bits; anything larger saturates anyway
      rx_q[0]      <= prx6_q;
      ry_q[0]      <= pry6_q;
      qx_q[0]      <= '0;
      qy_q[0]      <= '0;
      sb_q[0].sx   <= sx6_q;
      sb_q[0].sy   <= sy6_q;
      sb_q[0].dmag <= dmag6_q;
      sb_q[0].negx <= negx6_q;
      sb_q[0].negy <= negy6_q;
      sb_q[0].ovfx <= prx6_q >= dlim;
      sb_q[0].ovfy <= pry6_q >= dlim;
      sb_q[0].par  <= par6_q;

      for (int k = 1; k <= CW; k++) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  always_comb begin
    dmag4_d = den3_q[XW-1] ? MW'(-den3_q) : MW'(den3_q);
    nmag4_d = num3_q[XW-1] ? MW'(-num3_q) : MW'(num3_q);
  end

  assign dlim = PRW'(dmag6_q) << CW;

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int Sh = CW - 1 - k;
    logic [PRW-1:0] dsh;
    logic gex, gey;
    assign dsh        = PRW'(sb_q[k].dmag) << Sh;
    assign gex        = rx_q[k] >= dsh;
    assign gey        = ry_q[k] >= dsh;
    assign rx_d[k+1]  = gex ? rx_q[k] - dsh : rx_q[k];
    assign ry_d[k+1]  = gey ? ry_q[k] - dsh : ry_q[k];
    assign qx_d[k+1]  = qx_q[k] | (CW'(gex) << Sh);
    assign qy_d[k+1]  = qy_q[k] | (CW'(gey) << Sh);
  end

  // start +/- quotient, clamped; MSB of the result is the clamp flag
  function automatic logic [CW:0] finish(logic [CW-1:0] s, logic [CW-1:0] q,
                                         logic neg, logic ovf);
    logic signed [RW-1:0] r, mx, mn;
    mx = {3'b000, {(CW-1){1'b1}}};
    mn = {3'b111, {(CW-1){1'b0}}};
    r  = neg ? RW'($signed(s)) - $signed({2'b00, q})
             : RW'($signed(s)) + $signed({2'b00, q});
    if (ovf) begin
      return neg ? {1'b1, mn[CW-1:0]} : {1'b1, mx[CW-1:0]};
    end else if (r > mx) begin
      return {1'b1, mx[CW-1:0]};
    end else if (r < mn) begin
      return {1'b1, mn[CW-1:0]};
    end
    return {1'b0, r[CW-1:0]};
  endfunction

  assign fx = finish(sb_q[CW].sx, qx_q[CW], sb_q[CW].negx, sb_q[CW].ovfx);
  assign fy = finish(sb_q[CW].sy, qy_q[CW], sb_q[CW].negy, sb_q[CW].ovfy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sb_q[CW].par) begin
        out_chan.intersects <= 1'b0;
        out_chan.cross_x    <= '0;
        out_chan.cross_y    <= '0;
        out_chan.saturated  <= 1'b0;
      end else begin
        out_chan.intersects <= 1'b1;
        out_chan.cross_x    <= fx[CW-1:0];
        out_chan.cross_y    <= fy[CW-1:0];
        out_chan.saturated  <= fx[CW] | fy[CW];
      end
    end
  end

  assign out_chan.valid = out_valid_q;

endmodule

// ===== sv/lli_checker.sv =====
// Port-level checks for the line-line intersection block.
`timescale 1ns / 1ps
module lli_props import lli_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 intersects,
  input logic signed [CW-1:0] cross_x,
  input logic signed [CW-1:0] cross_y,
  input logic                 saturated
);

  localparam logic [CW-1:0] MaxC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MinC = {1'b1, {(CW-1){1'b0}}};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !intersects |-> cross_x == '0 && cross_y == '0 && !saturated)
    else $error("parallel result not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |->
      cross_x == MaxC || cross_x == MinC || cross_y == MaxC || cross_y == MinC)
    else $error("saturated flag without clamped coordinate");

endmodule

bind line_line_intersection lli_props #(.CW(COORD_WIDTH)) u_lli_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .intersects (out_chan.intersects),
  .cross_x    (out_chan.cross_x),
  .cross_y    (out_chan.cross_y),
  .saturated  (out_chan.saturated)
);
